// ===== src/csmp_pkg.sv =====
// ----------------------------------------------------------------------------
// Color span markup parser package
// Field widths, character codes and helpers shared by the parser and its
// checker.
// ----------------------------------------------------------------------------
package csmp_pkg;

  // Default line capacity in visible characters.
  localparam int unsigned MAX_LINE_DEF = 1024;

  // Field widths fixed by the stream format.
  localparam int unsigned CHAR_W  = 16;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned COLOR_W = 24;

  // Output word layout, lowest bit first.
  localparam int unsigned OD_CHAR_LO  = 0;
  localparam int unsigned OD_INDEX_LO = OD_CHAR_LO + CHAR_W;
  localparam int unsigned OD_START_LO = OD_INDEX_LO + INDEX_W;
  localparam int unsigned OD_SLEN_LO  = OD_START_LO + INDEX_W;
  localparam int unsigned OD_COLOR_LO = OD_SLEN_LO + LEN_W;
  localparam int unsigned OD_LLEN_LO  = OD_COLOR_LO + COLOR_W;
  localparam int unsigned OD_USED_W   = OD_LLEN_LO + LEN_W;
  localparam int unsigned OUT_DATA_W  = ((OD_USED_W + 7) / 8) * 8;

  // Output sideband flags.
  localparam int unsigned OU_TEXT  = 0;
  localparam int unsigned OU_SPAN  = 1;
  localparam int unsigned OU_ERROR = 2;
  localparam int unsigned OUT_USER_W = 3;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_DEFAULT_COLOR = 1'b0;
  localparam logic [COLOR_W-1:0] DEFAULT_COLOR_RST = 24'hFFFFFF;

  // Character codes used by the markup syntax.
  localparam logic [CHAR_W-1:0] CH_LT    = 16'h003C;
  localparam logic [CHAR_W-1:0] CH_GT    = 16'h003E;
  localparam logic [CHAR_W-1:0] CH_EQ    = 16'h003D;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 16'h0027;
  localparam logic [CHAR_W-1:0] CH_HASH  = 16'h0023;
  localparam logic [CHAR_W-1:0] CH_SLASH = 16'h002F;
  localparam logic [CHAR_W-1:0] CH_D0    = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_D9    = 16'h0039;
  localparam logic [CHAR_W-1:0] CH_LA    = 16'h0061;
  localparam logic [CHAR_W-1:0] CH_LF    = 16'h0066;
  localparam logic [CHAR_W-1:0] CH_LZ    = 16'h007A;
  localparam logic [CHAR_W-1:0] CH_UA    = 16'h0041;
  localparam logic [CHAR_W-1:0] CH_UZ    = 16'h005A;

  // Number of hex digits in a color value.
  localparam logic [2:0] HEX_DIGITS = 3'd6;

  // Moves red from the high byte to the low byte and blue the other way.
  function automatic logic [COLOR_W-1:0] rgb_to_bgr(input logic [COLOR_W-1:0] rgb);
    return {rgb[7:0], rgb[15:8], rgb[23:16]};
  endfunction

endpackage

// ===== src/color_span_markup_parser_top.sv =====
// ----------------------------------------------------------------------------
// Color span markup parser
// Splits a stream of line characters into visible text and colored spans.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake        | Contents
//  ---------+-----------+------------------+------------------------------------
//  in_      | sink      | tvalid / tready  | one character, tlast = end of line
//  out_     | source    | tvalid / tready  | text, span and line results, one
//           |           |                  | word per input word
//  cfg_     | APB slave | psel / penable   | default_color at byte address 0
//
//  The parse step for each input word is a small state transition computed
//  straight from the input word and the parser state, and its result lands
//  in the output register at the same edge that updates the state.
//  A new word is accepted every cycle while the output register is empty or
//  being drained, so throughput is one word a cycle.
//  When the output side stalls, in_tready drops until the waiting word is taken.
//  Reset is synchronous and active low; it returns the parser to plain text at
//  the start of a line and restores the default color to white.
//
module color_span_markup_parser_top #(
  parameter int unsigned MAX_LINE = csmp_pkg::MAX_LINE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [csmp_pkg::CHAR_W-1:0]         in_tdata,   // [15:0] char_code
  input  logic                                in_tlast,   // last_char
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [15:0] text_char, [25:16] text_index, [35:26] span_start,
  // [46:36] span_length, [70:47] span_color, [81:71] line_length, rest zero
  output logic [csmp_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [0] text_valid, [1] span_valid, [2] markup_error
  output logic [csmp_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                                out_tlast,  // line_done
  // Configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [csmp_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [csmp_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [csmp_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import csmp_pkg::*;

  // Position counters must hold MAX_LINE itself.
  localparam int unsigned POS_W = $clog2(MAX_LINE + 1);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LINE);

  // Parser modes.
  localparam logic [3:0] M_PLAIN = 4'd0;
  localparam logic [3:0] M_RUN   = 4'd1;
  localparam logic [3:0] M_TAG   = 4'd2;
  localparam logic [3:0] M_QUOTE = 4'd3;
  localparam logic [3:0] M_VALUE = 4'd4;
  localparam logic [3:0] M_GT    = 4'd5;
  localparam logic [3:0] M_INNER = 4'd6;
  localparam logic [3:0] M_SLASH = 4'd7;
  localparam logic [3:0] M_CLOSE = 4'd8;
  localparam logic [3:0] M_DROP  = 4'd9;

  // Parser state.
  logic [3:0]         mode_r,      mode_nxt;
  logic [POS_W-1:0]   pos_r,       pos_nxt;
  logic [POS_W-1:0]   run_start_r, run_start_nxt;
  logic [POS_W-1:0]   run_len_r,   run_len_nxt;
  logic [COLOR_W-1:0] color_r,     color_nxt;
  logic [2:0]         vcount_r,    vcount_nxt;
  logic [COLOR_W-1:0] default_color_r;

  // Output register.
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;
  logic                  out_last_r, out_last_nxt;

  // Per-word step signals.
  logic               in_fire;
  logic [CHAR_W-1:0]  ch;
  logic               can_put;
  logic               err;
  logic               text_vld;
  logic [POS_W-1:0]   text_pos;
  logic               span_vld;
  logic [POS_W-1:0]   span_start;
  logic [POS_W-1:0]   span_len;
  logic [COLOR_W-1:0] span_color;
  logic [3:0]         hex_nib;
  logic               hex_ok;
  logic [31:0]        text_pos_ext;
  logic [31:0]        span_start_ext;
  logic [31:0]        span_len_ext;
  logic [31:0]        line_len_ext;
  logic               cfg_wr;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign ch        = in_tdata;
  assign can_put   = pos_r < POS_LIMIT;

  // Lowercase hex digit decode.
  always_comb begin
    hex_ok  = 1'b0;
    hex_nib = 4'd0;
    if (ch inside {[CH_D0:CH_D9]}) begin
      hex_ok  = 1'b1;
      hex_nib = ch[3:0];
    end else if (ch inside {[CH_LA:CH_LF]}) begin
      hex_ok  = 1'b1;
      hex_nib = 4'(ch[3:0] + 4'd9);
    end
  end

  // One parse step for the word on the input.
  always_comb begin
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    run_start_nxt = run_start_r;
    run_len_nxt   = run_len_r;
    color_nxt     = color_r;
    vcount_nxt    = vcount_r;
    err           = 1'b0;
    text_vld      = 1'b0;
    text_pos      = pos_r;
    span_vld      = 1'b0;
    span_start    = run_start_r;
    span_len      = run_len_r;
    span_color    = default_color_r;

    case (mode_r)
      M_PLAIN: begin
        if (ch == CH_LT) begin
          mode_nxt = M_TAG;
        end else if (can_put) begin
          text_vld      = 1'b1;
          pos_nxt       = POS_W'(pos_r + 1'b1);
          run_start_nxt = pos_r;
          run_len_nxt   = POS_W'(1);
          mode_nxt      = M_RUN;
        end else begin
          err = 1'b1;
        end
      end
      M_RUN: begin
        if (ch == CH_LT) begin
          // A markup element closes the plain run in front of it.
          span_vld = 1'b1;
          mode_nxt = M_TAG;
        end else if (can_put) begin
          text_vld    = 1'b1;
          pos_nxt     = POS_W'(pos_r + 1'b1);
          run_len_nxt = POS_W'(run_len_r + 1'b1);
        end else begin
          err = 1'b1;
        end
      end
      M_TAG: begin
        if (ch == CH_EQ) begin
          mode_nxt = M_QUOTE;
        end else if (!(ch inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]})) begin
          err = 1'b1;
        end
      end
      M_QUOTE: begin
        if (ch == CH_QUOTE) begin
          mode_nxt   = M_VALUE;
          vcount_nxt = 3'd0;
          color_nxt  = '0;
        end else begin
          err = 1'b1;
        end
      end
      M_VALUE: begin
        if (vcount_r == 3'd0) begin
          if (ch == CH_HASH) vcount_nxt = 3'd1;
          else               err = 1'b1;
        end else if (vcount_r <= HEX_DIGITS) begin
          if (hex_ok) begin
            color_nxt  = {color_r[COLOR_W-5:0], hex_nib};
            vcount_nxt = 3'(vcount_r + 1'b1);
          end else begin
            err = 1'b1;
          end
        end else begin
          if (ch == CH_QUOTE) mode_nxt = M_GT;
          else                err = 1'b1;
        end
      end
      M_GT: begin
        if (ch == CH_GT) begin
          mode_nxt      = M_INNER;
          run_start_nxt = pos_r;
          run_len_nxt   = '0;
        end else begin
          err = 1'b1;
        end
      end
      M_INNER: begin
        if (ch == CH_LT) begin
          mode_nxt = M_SLASH;
        end else if (can_put) begin
          text_vld    = 1'b1;
          pos_nxt     = POS_W'(pos_r + 1'b1);
          run_len_nxt = POS_W'(run_len_r + 1'b1);
        end else begin
          err = 1'b1;
        end
      end
      M_SLASH: begin
        if (ch == CH_SLASH) mode_nxt = M_CLOSE;
        else                err = 1'b1;
      end
      M_CLOSE: begin
        if (ch == CH_GT) begin
          span_vld   = 1'b1;
          span_color = rgb_to_bgr(color_r);
          mode_nxt   = M_PLAIN;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        // Dropping the rest of the line; unused codes behave the same.
      end
    endcase

    if (err) mode_nxt = M_DROP;

    // Line end: flush an open plain run, flag an unfinished element, and
    // report the line length before clearing the line state, element color included.
    out_last_nxt = in_tlast;
    line_len_ext = 32'(pos_nxt);
    if (in_tlast) begin
      if (mode_nxt == M_RUN) begin
        span_vld   = 1'b1;
        span_start = run_start_nxt;
        span_len   = run_len_nxt;
        span_color = default_color_r;
      end else if (mode_nxt != M_PLAIN && mode_nxt != M_DROP) begin
        err = 1'b1;
      end
      mode_nxt      = M_PLAIN;
      pos_nxt       = '0;
      run_start_nxt = '0;
      run_len_nxt   = '0;
      color_nxt     = '0;
      vcount_nxt    = 3'd0;
    end else begin
      line_len_ext = '0;
    end

    text_pos_ext   = text_vld ? 32'(text_pos)   : 32'd0;
    span_start_ext = span_vld ? 32'(span_start) : 32'd0;
    span_len_ext   = span_vld ? 32'(span_len)   : 32'd0;

    out_data_nxt = '0;
    out_data_nxt[OD_CHAR_LO  +: CHAR_W]  = text_vld ? ch : '0;
    out_data_nxt[OD_INDEX_LO +: INDEX_W] = text_pos_ext[INDEX_W-1:0];
    out_data_nxt[OD_START_LO +: INDEX_W] = span_start_ext[INDEX_W-1:0];
    out_data_nxt[OD_SLEN_LO  +: LEN_W]   = span_len_ext[LEN_W-1:0];
    out_data_nxt[OD_COLOR_LO +: COLOR_W] = span_vld ? span_color : '0;
    out_data_nxt[OD_LLEN_LO  +: LEN_W]   = line_len_ext[LEN_W-1:0];

    out_user_nxt           = '0;
    out_user_nxt[OU_TEXT]  = text_vld;
    out_user_nxt[OU_SPAN]  = span_vld;
    out_user_nxt[OU_ERROR] = err;
  end

  // Parser state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_PLAIN;
      pos_r       <= '0;
      run_start_r <= '0;
      run_len_r   <= '0;
      color_r     <= '0;
      vcount_r    <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_r      <= mode_nxt;
        pos_r       <= pos_nxt;
        run_start_r <= run_start_nxt;
        run_len_r   <= run_len_nxt;
        color_r     <= color_nxt;
        vcount_r    <= vcount_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // Configuration register. The register index is the word address, so the
  // low two address bits are ignored.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_color_r <= DEFAULT_COLOR_RST;
    end else if (cfg_wr && cfg_paddr[2] == REG_DEFAULT_COLOR) begin
      default_color_r <= cfg_pwdata[COLOR_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_DEFAULT_COLOR) ?
                      CFG_DATA_W'(default_color_r) : '0;

endmodule

// ===== src/csmp_checker.sv =====
// ----------------------------------------------------------------------------
// Color span markup parser checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module csmp_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [csmp_pkg::OUT_DATA_W-1:0]     out_tdata,
  input logic [csmp_pkg::OUT_USER_W-1:0]     out_tuser,
  input logic                                out_tlast
);
  import csmp_pkg::*;

  // A stalled result word must not change under the consumer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // With a full output register and a stalled consumer, no new character may
  // be taken, or a result would be overwritten.
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while result register is blocked");

  // Text fields are zero when no character is emitted.
  a_text_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[OU_TEXT] |->
      out_tdata[OD_START_LO-1:0] == '0)
    else $error("text fields set without text_valid");

  // Line length is reported only at the end of a line.
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[OD_LLEN_LO +: LEN_W] == '0)
    else $error("line_length set without line_done");

endmodule

bind color_span_markup_parser_top csmp_checker u_csmp_checker (.*);

// ===== tb/sv/color_span_markup_parser_top_tb.sv =====
// ----------------------------------------------------------------------------
// Color span markup parser testbench
// Streams markup lines into the parser and checks every result word against
// a cycle-free model of the span parser kept inside this bench. A short
// directed table comes first, then random lines built mostly from well-formed
// elements and plain runs, with broken elements, noise and one overlong line
// mixed in. Both stream sides idle at random, and the default color is
// rewritten between phases while the parser is idle.
// ----------------------------------------------------------------------------
module color_span_markup_parser_top_tb;
  import csmp_pkg::*;

  // Parser modes of the checking model.
  typedef enum logic [3:0] {
    PM_PLAIN, PM_RUN, PM_TAG, PM_QUOTE, PM_VALUE,
    PM_GT, PM_INNER, PM_SLASH, PM_CLOSE, PM_DROP
  } parse_mode_e;

  // One result word, in field order.
  typedef struct packed {
    logic               text_valid;
    logic [CHAR_W-1:0]  text_char;
    logic [INDEX_W-1:0] text_index;
    logic               span_valid;
    logic [INDEX_W-1:0] span_start;
    logic [LEN_W-1:0]   span_length;
    logic [COLOR_W-1:0] span_color;
    logic               line_done;
    logic [LEN_W-1:0]   line_length;
    logic               markup_error;
  } parse_result_t;

  // One row of the directed table. When typed is set, want is the result
  // word written out by hand; otherwise the model supplies it.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              typed;
    parse_result_t     want;
  } stim_row_t;

  localparam parse_result_t NO_WORD = '0;
  localparam parse_result_t ERR_ONLY = '{1'b0, 16'h0, 10'd0, 1'b0, 10'd0, 11'd0,
                                         24'h0, 1'b0, 11'd0, 1'b1};
  localparam int unsigned STIM_ROWS = 29;
  localparam int unsigned HEX_COUNT = 6;

  // Directed rows. The first line is a single character at the top of the
  // code range, checked against the reset default color. Then a line that
  // opens with code zero, closes the plain run at an element with an
  // uppercase and a lowercase tag letter and uses the digit extremes, and
  // ends with an element whose inner text is empty. After that come an
  // element with no tag name and an uppercase hex digit (dropping until
  // the line end), a line ending right after '<', and a bad tag letter.
  localparam stim_row_t STIM_TABLE [STIM_ROWS] = '{
    '{16'hFFFF, 1'b1, 1'b1, '{1'b1, 16'hFFFF, 10'd0, 1'b1, 10'd0, 11'd1,
                              24'hFFFFFF, 1'b1, 11'd1, 1'b0}},
    '{16'h0000, 1'b0, 1'b1, '{1'b1, 16'h0000, 10'd0, 1'b0, 10'd0, 11'd0,
                              24'h0, 1'b0, 11'd0, 1'b0}},
    '{CH_LT,    1'b0, 1'b0, NO_WORD},
    '{CH_LZ,    1'b0, 1'b0, NO_WORD},
    '{CH_UA,    1'b0, 1'b0, NO_WORD},
    '{CH_EQ,    1'b0, 1'b0, NO_WORD},
    '{CH_QUOTE, 1'b0, 1'b0, NO_WORD},
    '{CH_HASH,  1'b0, 1'b0, NO_WORD},
    '{CH_LF,    1'b0, 1'b0, NO_WORD},
    '{CH_D0,    1'b0, 1'b0, NO_WORD},
    '{CH_D9,    1'b0, 1'b0, NO_WORD},
    '{CH_LA,    1'b0, 1'b0, NO_WORD},
    '{16'h0031, 1'b0, 1'b0, NO_WORD},
    '{16'h0032, 1'b0, 1'b0, NO_WORD},
    '{CH_QUOTE, 1'b0, 1'b0, NO_WORD},
    '{CH_GT,    1'b0, 1'b0, NO_WORD},
    '{CH_LT,    1'b0, 1'b0, NO_WORD},
    '{CH_SLASH, 1'b0, 1'b0, NO_WORD},
    '{CH_GT,    1'b1, 1'b0, NO_WORD},
    '{CH_LT,    1'b0, 1'b0, NO_WORD},
    '{CH_EQ,    1'b0, 1'b0, NO_WORD},
    '{CH_QUOTE, 1'b0, 1'b0, NO_WORD},
    '{CH_HASH,  1'b0, 1'b0, NO_WORD},
    '{16'h0046, 1'b0, 1'b1, ERR_ONLY},
    '{16'h0078, 1'b1, 1'b1, '{1'b0, 16'h0, 10'd0, 1'b0, 10'd0, 11'd0,
                              24'h0, 1'b1, 11'd0, 1'b0}},
    '{CH_LT,    1'b1, 1'b1, '{1'b0, 16'h0, 10'd0, 1'b0, 10'd0, 11'd0,
                              24'h0, 1'b1, 11'd0, 1'b1}},
    '{CH_LT,    1'b0, 1'b0, NO_WORD},
    '{16'h0037, 1'b0, 1'b1, ERR_ONLY},
    '{16'h0071, 1'b1, 1'b1, '{1'b0, 16'h0, 10'd0, 1'b0, 10'd0, 11'd0,
                              24'h0, 1'b1, 11'd0, 1'b0}}
  };

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [CHAR_W-1:0]       in_tdata;   // [15:0] char_code
  logic                    in_tlast;   // last_char
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_DATA_W-1:0]   out_tdata;  // text_char, text_index, span_start,
                                       // span_length, span_color, line_length
  logic [OUT_USER_W-1:0]   out_tuser;  // text_valid, span_valid, markup_error
  logic                    out_tlast;  // line_done
  logic                    cfg_psel;
  logic                    cfg_penable;
  logic                    cfg_pwrite;
  logic [CFG_ADDR_W-1:0]   cfg_paddr;
  logic [CFG_DATA_W-1:0]   cfg_pwdata;
  logic [CFG_DATA_W-1:0]   cfg_prdata;
  logic                    cfg_pready;

  color_span_markup_parser_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Result words predicted for accepted characters, oldest first.
  parse_result_t pending_results[$];
  int unsigned   err_count;
  // When set, neither side inserts idle cycles.
  bit            no_idle;
  int unsigned   ready_hold;
  // Characters of the line being built.
  logic [CHAR_W-1:0] line_buf[$];

  // State of the checking model.
  logic [COLOR_W-1:0] plain_color;
  parse_mode_e        pm_mode;
  logic [LEN_W-1:0]   out_pos;
  logic [LEN_W-1:0]   span_first;
  logic [LEN_W-1:0]   span_count;
  logic [COLOR_W-1:0] hex_accum;
  logic [2:0]         hex_seen;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Generous watchdog: the slowest correct run is far shorter.
  initial begin
    #2000000;
    $display("color_span_markup_parser_top_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Checking model of the parser.
  // ---------------------------------------------------------------------------
  function automatic void clear_line();
    pm_mode    = PM_PLAIN;
    out_pos    = '0;
    span_first = '0;
    span_count = '0;
    hex_accum  = '0;
    hex_seen   = '0;
  endfunction

  // Emits one visible character; returns 0 when the line is already full.
  function automatic bit emit_char(input logic [CHAR_W-1:0] c, inout parse_result_t r);
    if (out_pos >= LEN_W'(MAX_LINE_DEF))
      return 1'b0;
    r.text_valid = 1'b1;
    r.text_char  = c;
    r.text_index = out_pos[INDEX_W-1:0];
    out_pos++;
    span_count++;
    return 1'b1;
  endfunction

  function automatic void close_span(input logic [COLOR_W-1:0] color,
                                     inout parse_result_t r);
    r.span_valid  = 1'b1;
    r.span_start  = span_first[INDEX_W-1:0];
    r.span_length = span_count;
    r.span_color  = color;
  endfunction

  function automatic parse_result_t predict_step(input logic [CHAR_W-1:0] c,
                                                 input logic last_c);
    parse_result_t    r;
    bit               bad;
    logic [LEN_W-1:0] pos_was;
    logic [3:0]       nib;
    r   = '0;
    bad = 1'b0;
    case (pm_mode)
      PM_PLAIN: begin
        if (c == CH_LT) begin
          pm_mode = PM_TAG;
        end else begin
          pos_was    = out_pos;
          span_count = '0;
          if (emit_char(c, r)) begin
            span_first = pos_was;
            pm_mode    = PM_RUN;
          end else begin
            bad = 1'b1;
          end
        end
      end
      PM_RUN: begin
        if (c == CH_LT) begin
          close_span(plain_color, r);
          pm_mode = PM_TAG;
        end else if (!emit_char(c, r)) begin
          bad = 1'b1;
        end
      end
      PM_TAG: begin
        if (c == CH_EQ)
          pm_mode = PM_QUOTE;
        else if (!((c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ)))
          bad = 1'b1;
      end
      PM_QUOTE: begin
        if (c == CH_QUOTE) begin
          pm_mode   = PM_VALUE;
          hex_seen  = '0;
          hex_accum = '0;
        end else begin
          bad = 1'b1;
        end
      end
      PM_VALUE: begin
        // hex_seen counts the '#' and then each digit taken so far.
        if (hex_seen == 3'd0) begin
          if (c == CH_HASH)
            hex_seen = 3'd1;
          else
            bad = 1'b1;
        end else if (hex_seen <= HEX_DIGITS) begin
          if (c >= CH_D0 && c <= CH_D9) begin
            nib = 4'(c - CH_D0);
          end else if (c >= CH_LA && c <= CH_LF) begin
            nib = 4'(c - CH_LA + 16'd10);
          end else begin
            nib = '0;
            bad = 1'b1;
          end
          if (!bad) begin
            hex_accum = {hex_accum[COLOR_W-5:0], nib};
            hex_seen++;
          end
        end else if (c == CH_QUOTE) begin
          pm_mode = PM_GT;
        end else begin
          bad = 1'b1;
        end
      end
      PM_GT: begin
        if (c == CH_GT) begin
          pm_mode    = PM_INNER;
          span_first = out_pos;
          span_count = '0;
        end else begin
          bad = 1'b1;
        end
      end
      PM_INNER: begin
        if (c == CH_LT)
          pm_mode = PM_SLASH;
        else if (!emit_char(c, r))
          bad = 1'b1;
      end
      PM_SLASH: begin
        if (c == CH_SLASH)
          pm_mode = PM_CLOSE;
        else
          bad = 1'b1;
      end
      PM_CLOSE: begin
        if (c == CH_GT) begin
          // The element color arrives as RGB and leaves with red in the low byte.
          close_span({hex_accum[7:0], hex_accum[15:8], hex_accum[23:16]}, r);
          pm_mode = PM_PLAIN;
        end else begin
          bad = 1'b1;
        end
      end
      default: ;
    endcase
    if (bad)
      pm_mode = PM_DROP;
    if (last_c) begin
      if (pm_mode == PM_RUN)
        close_span(plain_color, r);
      else if (pm_mode != PM_PLAIN && pm_mode != PM_DROP)
        bad = 1'b1;
      r.line_done   = 1'b1;
      r.line_length = out_pos;
      clear_line();
    end
    r.markup_error = bad;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly none or short, now and then a long one.
  // ---------------------------------------------------------------------------
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 85)
      return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic int unsigned send_gap();
    if (no_idle || $urandom_range(0, 99) < 55)
      return 0;
    return idle_len();
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and checking of every accepted word.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold--;
      out_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 25) begin
      ready_hold = idle_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    parse_result_t got;
    parse_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.text_valid   = out_tuser[OU_TEXT];
      got.text_char    = out_tdata[OD_CHAR_LO +: CHAR_W];
      got.text_index   = out_tdata[OD_INDEX_LO +: INDEX_W];
      got.span_valid   = out_tuser[OU_SPAN];
      got.span_start   = out_tdata[OD_START_LO +: INDEX_W];
      got.span_length  = out_tdata[OD_SLEN_LO +: LEN_W];
      got.span_color   = out_tdata[OD_COLOR_LO +: COLOR_W];
      got.line_done    = out_tlast;
      got.line_length  = out_tdata[OD_LLEN_LO +: LEN_W];
      got.markup_error = out_tuser[OU_ERROR];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got 0x%0h", $time, got);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("text_valid",   want.text_valid,   got.text_valid);
        check_field("text_char",    want.text_char,    got.text_char);
        check_field("text_index",   want.text_index,   got.text_index);
        check_field("span_valid",   want.span_valid,   got.span_valid);
        check_field("span_start",   want.span_start,   got.span_start);
        check_field("span_length",  want.span_length,  got.span_length);
        check_field("span_color",   want.span_color,   got.span_color);
        check_field("line_done",    want.line_done,    got.line_done);
        check_field("line_length",  want.line_length,  got.line_length);
        check_field("markup_error", want.markup_error, got.markup_error);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------
  // Offers one character and waits until it is taken. The prediction is made
  // at the accepting edge; a typed row replaces it with its hand-written word.
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last_c,
                           input logic typed, input parse_result_t want);
    int unsigned   gap;
    parse_result_t model_word;
    gap = send_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last_c;
    do @(posedge clk); while (!in_tready);
    model_word = predict_step(c, last_c);
    pending_results.push_back(typed ? want : model_word);
  endtask

  // Waits until every predicted word has come back, then lets the parser's
  // output register drain a little longer.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes default_color through the APB port and reads it back.
  task automatic write_color(input logic [COLOR_W-1:0] color);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(4 * REG_DEFAULT_COLOR);
    cfg_pwdata  <= {8'($urandom), color};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    plain_color = color;
    // Read-back: setup, then sample mid access cycle.
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    if (cfg_prdata !== CFG_DATA_W'(color)) begin
      $display("%0t: default_color read-back mismatch, expected 0x%0h, got 0x%0h",
               $time, color, cfg_prdata);
      err_count++;
    end
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Line builder.
  // ---------------------------------------------------------------------------
  // Any code except '<', mostly printable, sometimes the full 16-bit range.
  function automatic logic [CHAR_W-1:0] plain_char();
    logic [CHAR_W-1:0] c;
    do begin
      if ($urandom_range(0, 9) < 6)
        c = CHAR_W'($urandom_range(16'h0020, 16'h007E));
      else
        c = CHAR_W'($urandom);
    end while (c == CH_LT);
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char();
    int unsigned v;
    v = $urandom_range(0, 15);
    return (v < 10) ? CHAR_W'(CH_D0 + v) : CHAR_W'(CH_LA + v - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] letter_char();
    if ($urandom_range(0, 1) != 0)
      return CHAR_W'(CH_LA + $urandom_range(0, 25));
    return CHAR_W'(CH_UA + $urandom_range(0, 25));
  endfunction

  // Markup punctuation or anything at all.
  function automatic logic [CHAR_W-1:0] noise_char();
    case ($urandom_range(0, 6))
      0: return CH_LT;
      1: return CH_GT;
      2: return CH_EQ;
      3: return CH_QUOTE;
      4: return CH_HASH;
      5: return CH_SLASH;
      default: return CHAR_W'($urandom);
    endcase
  endfunction

  function automatic void add_plain(input int unsigned len);
    repeat (len) line_buf.push_back(plain_char());
  endfunction

  // Appends one element and returns the length of its inner text. A broken
  // element has one defect: a replaced character, a missing or extra hex
  // digit, an uppercase digit, or a cut that ends the line inside it.
  function automatic int unsigned add_element(input bit broken, output bit cut);
    logic [CHAR_W-1:0] el[$];
    int unsigned       names;
    int unsigned       hash_at;
    int unsigned       inner;
    int unsigned       k;
    names = $urandom_range(0, 3);
    el.push_back(CH_LT);
    repeat (names) el.push_back(letter_char());
    el.push_back(CH_EQ);
    el.push_back(CH_QUOTE);
    hash_at = el.size();
    el.push_back(CH_HASH);
    repeat (HEX_COUNT) el.push_back(hex_char());
    el.push_back(CH_QUOTE);
    el.push_back(CH_GT);
    inner = $urandom_range(0, 5);
    repeat (inner) el.push_back(plain_char());
    el.push_back(CH_LT);
    el.push_back(CH_SLASH);
    el.push_back(CH_GT);
    cut = 1'b0;
    if (broken) begin
      k = hash_at + $urandom_range(1, HEX_COUNT);
      case ($urandom_range(0, 4))
        0: el[$urandom_range(0, el.size() - 1)] = noise_char();
        1: el.delete(k);
        2: el.insert(k, hex_char());
        3: el[k] = CHAR_W'(CH_UA + $urandom_range(0, 5));
        default: begin
          el  = el[0:$urandom_range(0, el.size() - 2)];
          cut = 1'b1;
        end
      endcase
    end
    foreach (el[i]) line_buf.push_back(el[i]);
    return inner;
  endfunction

  // Builds one line into line_buf. A long line keeps adding well-formed
  // content until it runs past the line capacity.
  function automatic void build_line(input bit long_line);
    int unsigned segs;
    int unsigned visible;
    int unsigned n;
    int unsigned pick;
    bit          cut;
    line_buf.delete();
    if (long_line) begin
      visible = 0;
      while (visible < MAX_LINE_DEF + 8) begin
        if ($urandom_range(0, 3) == 0) begin
          visible += add_element(1'b0, cut);
        end else begin
          n = $urandom_range(20, 60);
          add_plain(n);
          visible += n;
        end
      end
    end else begin
      segs = $urandom_range(1, 6);
      cut  = 1'b0;
      for (int s = 0; s < segs && !cut; s++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)
          add_plain($urandom_range(1, 8));
        else if (pick < 90)
          void'(add_element($urandom_range(0, 99) < 15, cut));
        else
          repeat ($urandom_range(1, 3)) line_buf.push_back(noise_char());
      end
    end
  endfunction

  task automatic send_line(input bit long_line);
    build_line(long_line);
    foreach (line_buf[i])
      send_char(line_buf[i], i == line_buf.size() - 1, 1'b0, NO_WORD);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    logic [COLOR_W-1:0] phase_color [6];
    int unsigned        sent;
    // Every input is known from time zero.
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    err_count   = 0;
    no_idle     = 1'b0;
    ready_hold  = 0;
    plain_color = DEFAULT_COLOR_RST;
    clear_line();

    // Settings for the random phases, both extremes among them.
    phase_color[0] = 24'h000000;
    phase_color[1] = 24'hFFFFFF;
    phase_color[2] = COLOR_W'($urandom);
    phase_color[3] = 24'hFF0000;
    phase_color[4] = COLOR_W'($urandom);
    phase_color[5] = 24'h00FF00;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under the reset default color.
    foreach (STIM_TABLE[i])
      send_char(STIM_TABLE[i].ch, STIM_TABLE[i].last, STIM_TABLE[i].typed,
                STIM_TABLE[i].want);

    // Random phases, each under a new default color written while idle.
    // One phase runs without idle cycles on either side, and one carries a
    // line long enough to overflow the output line.
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_color(phase_color[p]);
      no_idle = (p == 2);
      if (p == 3)
        send_line(1'b1);
      sent = 0;
      while (sent < 20) begin
        send_line(1'b0);
        sent += line_buf.size();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (err_count == 0)
      $display("color_span_markup_parser_top_tb: done, clean");
    else
      $display("color_span_markup_parser_top_tb: done, errors");
    $finish;
  end

endmodule
